FILE: src/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and helpers for the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ENT_W     = 32;
    localparam int ADJ_W     = 64;
    // Three 32x64 products summed.
    localparam int DET_W     = 98;
    localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;
    // Quotient bits produced by the divider, enough to detect saturation.
    localparam int QB        = 33;
    localparam int UNS_W     = ADJ_W + 1 - FRAC_BITS;
    localparam int FRONT_STAGES = 5;
    localparam int QUEUE_STAGES = 2;
    localparam int LATENCY   = FRONT_STAGES + QUEUE_STAGES + 2 + QB + 2;

    typedef logic signed [ENT_W-1:0] ent_t;
    typedef logic signed [ADJ_W-1:0] adj_t;
    typedef logic signed [DET_W-1:0] det_t;

    typedef struct packed {
        logic       bad;
        det_t       det;
        adj_t [8:0] adj;
    } job_t;

    // Saturate a sign-magnitude value to 32-bit two's complement.
    function automatic ent_t sat32(logic neg, logic [UNS_W-1:0] mag);
        ent_t res;
        if (!neg)
        begin
            res = (mag > UNS_W'(64'h7FFF_FFFF)) ? ent_t'(32'h7FFF_FFFF) : ent_t'(mag[31:0]);
        end
        else
        begin
            res = (mag > UNS_W'(64'h8000_0000)) ? ent_t'(32'h8000_0000)
                                                : ent_t'(~mag[31:0] + 32'd1);
        end
        return res;
    endfunction

endpackage

FILE: src/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front
// Accepts a matrix, forms the cofactors and the determinant, and flags
// matrices whose determinant is not positive.
// ----------------------------------------------------------------------------
module m3i_front
    import m3i_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  ent_t [8:0] mat,
    output logic       out_valid,
    output job_t       out_job
);

    logic [FRONT_STAGES-1:0] vld_reg;

    adj_t [8:0] p1_reg, p1_next;
    adj_t [8:0] p2_reg, p2_next;
    ent_t [2:0] row_s1_reg, row_s2_reg;
    adj_t [8:0] adj_s2_reg, adj_s3_reg, adj_s4_reg;
    logic signed [ADJ_W:0] lo_reg [3];
    logic signed [ADJ_W:0] lo_next [3];
    adj_t hi_reg [3];
    adj_t hi_next [3];
    det_t term_reg [3];
    det_t term_next [3];
    det_t det_next;
    job_t job_reg;

    always_comb
    begin
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                i1 = (i + 1) % 3;
                i2 = (i + 2) % 3;
                p1_next[i*3+j] = mat[j1*3+i1] * mat[j2*3+i2];
                p2_next[i*3+j] = mat[j1*3+i2] * mat[j2*3+i1];
            end
        end
    end

    // The 32x64 determinant terms are split into two 32x32 partial products.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_next[j] = row_s2_reg[j] * $signed({1'b0, adj_s2_reg[j*3][31:0]});
            hi_next[j] = row_s2_reg[j] * $signed(adj_s2_reg[j*3][63:32]);
            term_next[j] = (det_t'(hi_reg[j]) <<< 32) + det_t'(lo_reg[j]);
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        row_s1_reg <= mat[2:0];
        row_s2_reg <= row_s1_reg;
        for (int k = 0; k < 9; k++)
        begin
            adj_s2_reg[k] <= p1_reg[k] - p2_reg[k];
        end
        adj_s3_reg <= adj_s2_reg;
        adj_s4_reg <= adj_s3_reg;
        for (int j = 0; j < 3; j++)
        begin
            lo_reg[j]   <= lo_next[j];
            hi_reg[j]   <= hi_next[j];
            term_reg[j] <= term_next[j];
        end
        job_reg.adj <= adj_s4_reg;
        job_reg.det <= det_next;
        job_reg.bad <= det_next[DET_W-1] || (det_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_job   = job_reg;

endmodule

FILE: src/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue
// Two-entry queue between the classifying front and the divider back end.
// ----------------------------------------------------------------------------
module m3i_queue
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  job_t in_job,
    output logic full,
    output logic out_valid,
    output job_t out_job
);

    job_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       out_valid_reg;
    job_t       out_job_reg;
    logic       pop;

    assign pop        = (count_reg != 2'd0);
    assign count_next = count_reg + {1'b0, in_valid} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            mem[wr_ptr_reg] <= in_job;
        end
        if (pop)
        begin
            out_job_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg     <= count_next;
            out_valid_reg <= pop;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = out_valid_reg;
    assign out_job   = out_job_reg;

endmodule

FILE: src/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back
// Pipelined restoring division of the nine cofactors by the determinant,
// rounding, saturation and the fallback output for a determinant that is not positive.
// ----------------------------------------------------------------------------
module m3i_back
    import m3i_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  job_t       in_job,
    output logic       done,
    output ent_t [8:0] inv,
    output logic       not_inverted
);

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [DET_W-1:0] rem;
        logic [QB-1:0]    quo;
        logic [QB-1:0]    low;
    } lane_t;

    typedef struct packed {
        logic             bad;
        logic [DET_W-1:0] det;
        ent_t [2:0]       unsc;
    } ctl_t;

    function automatic lane_t div_step(lane_t l, logic [DET_W-1:0] d);
        lane_t      r;
        logic [DET_W:0] trial;
        r     = l;
        trial = {l.rem, l.low[QB-1]};
        if (trial >= {1'b0, d})
        begin
            r.rem = DET_W'(trial - {1'b0, d});
            r.quo = {l.quo[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DET_W-1:0];
            r.quo = {l.quo[QB-2:0], 1'b0};
        end
        r.low = {l.low[QB-2:0], 1'b0};
        return r;
    endfunction

    // Entry stage: magnitudes.
    logic             e1_vld_reg;
    logic [8:0]       e1_neg_reg;
    logic [ADJ_W-1:0] e1_mag_reg [9];
    logic [DET_W-1:0] e1_det_reg;
    logic             e1_bad_reg;

    // Division stages; stage 0 holds the initial partial remainder.
    lane_t [8:0] ln_reg  [QB+1];
    lane_t [8:0] ln_next [QB+1];
    ctl_t        ctl_reg [QB+1];
    ctl_t        ctl0_next;
    logic [QB:0] sv_reg;

    // Rounding stage.
    logic        rd_vld_reg;
    logic [QB:0] rd_q_reg [9];
    logic [8:0]  rd_neg_reg, rd_ovf_reg;
    ctl_t        rd_ctl_reg;

    // Output registers.
    logic       done_reg;
    ent_t [8:0] inv_reg;
    logic       bad_reg;

    always_comb
    begin
        logic [NUM_W-1:0] num;
        logic [ADJ_W:0]   sum;
        for (int l = 0; l < 9; l++)
        begin
            num = {e1_mag_reg[l], {(2*FRAC_BITS){1'b0}}};
            ln_next[0][l].neg = e1_neg_reg[l];
            ln_next[0][l].rem = DET_W'(num[NUM_W-1:QB]);
            ln_next[0][l].ovf = DET_W'(num[NUM_W-1:QB]) >= e1_det_reg;
            ln_next[0][l].quo = '0;
            ln_next[0][l].low = num[QB-1:0];
        end
        for (int k = 1; k <= QB; k++)
        begin
            for (int l = 0; l < 9; l++)
            begin
                ln_next[k][l] = div_step(ln_reg[k-1][l], ctl_reg[k-1].det);
            end
        end
        ctl0_next.bad = e1_bad_reg;
        ctl0_next.det = e1_det_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum = {1'b0, e1_mag_reg[i*3]} + (ADJ_W+1)'(1 << (FRAC_BITS - 1));
            ctl0_next.unsc[i] = sat32(e1_neg_reg[i*3], sum[ADJ_W:FRAC_BITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 9; l++)
        begin
            e1_neg_reg[l] <= in_job.adj[l][ADJ_W-1];
            e1_mag_reg[l] <= in_job.adj[l][ADJ_W-1] ? (~in_job.adj[l] + 1'b1) : in_job.adj[l];
        end
        e1_det_reg <= in_job.det;
        e1_bad_reg <= in_job.bad;

        ctl_reg[0] <= ctl0_next;
        for (int k = 0; k <= QB; k++)
        begin
            ln_reg[k] <= ln_next[k];
        end
        for (int k = 1; k <= QB; k++)
        begin
            ctl_reg[k] <= ctl_reg[k-1];
        end

        // Round to nearest: bump the quotient when twice the remainder reaches d.
        for (int l = 0; l < 9; l++)
        begin
            rd_q_reg[l] <= {1'b0, ln_reg[QB][l].quo}
                         + (QB+1)'({ln_reg[QB][l].rem, 1'b0} >= {1'b0, ctl_reg[QB].det});
            rd_neg_reg[l] <= ln_reg[QB][l].neg;
            rd_ovf_reg[l] <= ln_reg[QB][l].ovf;
        end
        rd_ctl_reg <= ctl_reg[QB];

        for (int l = 0; l < 9; l++)
        begin
            if (rd_ctl_reg.bad)
            begin
                inv_reg[l] <= (l % 3 == 0) ? rd_ctl_reg.unsc[l/3] : ent_t'(0);
            end
            else
            begin
                inv_reg[l] <= sat32(rd_neg_reg[l],
                                    rd_ovf_reg[l] ? {UNS_W{1'b1}} : UNS_W'(rd_q_reg[l]));
            end
        end
        bad_reg <= rd_ctl_reg.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            sv_reg     <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            e1_vld_reg <= in_valid;
            sv_reg     <= {sv_reg[QB-1:0], e1_vld_reg};
            rd_vld_reg <= sv_reg[QB];
            done_reg   <= rd_vld_reg;
        end
    end

    assign done         = done_reg;
    assign inv          = inv_reg;
    assign not_inverted = bad_reg;

endmodule

FILE: src/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverts a signed Q16.16 3x3 matrix by the adjugate and determinant.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes through 5 front stages, 2 queue
// stages, 2 divider entry stages, 33 divider stages and 2 rounding and
// output stages; done and the result are registered together.
// Throughput: one request per cycle; every stage takes a new request each cycle.
// The receiver cannot stall, so the two-entry queue always drains and busy
// stays low. Reset clears all valid bits; data registers are not reset.
module matrix3x3_inverse
    import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  ent_t in_r0c0,
    input  ent_t in_r0c1,
    input  ent_t in_r0c2,
    input  ent_t in_r1c0,
    input  ent_t in_r1c1,
    input  ent_t in_r1c2,
    input  ent_t in_r2c0,
    input  ent_t in_r2c1,
    input  ent_t in_r2c2,
    output logic done,
    output ent_t inv_r0c0,
    output ent_t inv_r0c1,
    output ent_t inv_r0c2,
    output ent_t inv_r1c0,
    output ent_t inv_r1c1,
    output ent_t inv_r1c2,
    output ent_t inv_r2c0,
    output ent_t inv_r2c1,
    output ent_t inv_r2c2,
    output logic not_inverted
);

    ent_t [8:0] mat;
    ent_t [8:0] inv;
    logic       fr_valid, q_valid, q_full;
    job_t       fr_job, q_job;

    assign mat = {in_r2c2, in_r2c1, in_r2c0, in_r1c2, in_r1c1, in_r1c0,
                  in_r0c2, in_r0c1, in_r0c0};
    assign busy = q_full;

    m3i_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .mat       (mat),
        .out_valid (fr_valid),
        .out_job   (fr_job)
    );

    m3i_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_job    (fr_job),
        .full      (q_full),
        .out_valid (q_valid),
        .out_job   (q_job)
    );

    m3i_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_job       (q_job),
        .done         (done),
        .inv          (inv),
        .not_inverted (not_inverted)
    );

    assign inv_r0c0 = inv[0];
    assign inv_r0c1 = inv[1];
    assign inv_r0c2 = inv[2];
    assign inv_r1c0 = inv[3];
    assign inv_r1c1 = inv[4];
    assign inv_r1c2 = inv[5];
    assign inv_r2c0 = inv[6];
    assign inv_r2c1 = inv[7];
    assign inv_r2c2 = inv[8];

endmodule

FILE: src/m3i_checker.sv
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on request latency, queue drain and not-inverted output.
// ----------------------------------------------------------------------------
module m3i_checker
    import m3i_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input ent_t inv_r0c1,
    input ent_t inv_r0c2,
    input ent_t inv_r1c1,
    input ent_t inv_r1c2,
    input ent_t inv_r2c1,
    input ent_t inv_r2c2,
    input logic not_inverted
);

    // Every accepted request comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request result missing at fixed latency");

    // A strobe is only produced for a request accepted one pipeline latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // The back end never stalls, so the queue never fills.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled up");

    // A not-inverted result carries data only in column zero.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && not_inverted) |-> (inv_r0c1 == 0 && inv_r0c2 == 0 && inv_r1c1 == 0
                                    && inv_r1c2 == 0 && inv_r2c1 == 0 && inv_r2c2 == 0))
        else $error("singular result has nonzero off-column entries");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);

FILE: tb/matrix3x3_inverse_test.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_test
// Sends 3x3 Q16.16 matrices with random gaps and checks every inverse, the
// saturation and the not-inverted path against a wide integer model.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_test;

    timeunit 1ns;
    timeprecision 1ps;

    import m3i_pkg::*;

    typedef ent_t mat_t [9];

    typedef struct {
        ent_t inv [9];
        logic flag;
    } inverse_t;

    localparam ent_t ONE     = ent_t'(1 << FRAC_BITS);
    localparam ent_t MAX_ENT = ent_t'(32'h7FFF_FFFF);
    localparam ent_t MIN_ENT = ent_t'(32'h8000_0000);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    ent_t in_ent [9];
    ent_t inv_ent [9];
    logic not_inverted;

    inverse_t pending_inverses [$];
    int errors = 0;

    initial
    begin
        for (int k = 0; k < 9; k++)
        begin
            in_ent[k] = '0;
        end
    end

    always #5 clk = ~clk;

    matrix3x3_inverse u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_r0c0(in_ent[0]), .in_r0c1(in_ent[1]), .in_r0c2(in_ent[2]),
        .in_r1c0(in_ent[3]), .in_r1c1(in_ent[4]), .in_r1c2(in_ent[5]),
        .in_r2c0(in_ent[6]), .in_r2c1(in_ent[7]), .in_r2c2(in_ent[8]),
        .done(done),
        .inv_r0c0(inv_ent[0]), .inv_r0c1(inv_ent[1]), .inv_r0c2(inv_ent[2]),
        .inv_r1c0(inv_ent[3]), .inv_r1c1(inv_ent[4]), .inv_r1c2(inv_ent[5]),
        .inv_r2c0(inv_ent[6]), .inv_r2c1(inv_ent[7]), .inv_r2c2(inv_ent[8]),
        .not_inverted(not_inverted)
    );

    function automatic ent_t clamp32(logic neg, logic [129:0] mag);
        ent_t res;
        if (!neg)
        begin
            res = (mag > 130'h7FFF_FFFF) ? MAX_ENT : ent_t'(mag[31:0]);
        end
        else
        begin
            res = (mag > 130'h8000_0000) ? MIN_ENT : ent_t'(-mag[31:0]);
        end
        return res;
    endfunction

    // Adjugate over determinant, all in exact wide integers.
    function automatic inverse_t invert_matrix(mat_t e);
        logic signed [127:0] w [3][3];
        logic signed [127:0] cof [3][3];
        logic signed [127:0] det;
        logic [129:0] mag;
        logic [129:0] num;
        logic [129:0] den;
        inverse_t res;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w[i][j] = e[i*3+j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cof[i][j] = w[(j+1)%3][(i+1)%3] * w[(j+2)%3][(i+2)%3]
                          - w[(j+1)%3][(i+2)%3] * w[(j+2)%3][(i+1)%3];
            end
        end
        det = w[0][0]*cof[0][0] + w[0][1]*cof[1][0] + w[0][2]*cof[2][0];
        res.flag = (det <= 0);
        den = {2'b00, det};
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mag = cof[i][j][127] ? 130'(-cof[i][j]) : 130'(cof[i][j]);
                if (!res.flag)
                begin
                    num = mag << (2 * FRAC_BITS);
                    res.inv[i*3+j] = clamp32(cof[i][j][127], (2*num + den) / (2*den));
                end
                else if (j == 0)
                begin
                    num = (mag + (130'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    res.inv[i*3+j] = clamp32(cof[i][j][127], num);
                end
                else
                begin
                    res.inv[i*3+j] = '0;
                end
            end
        end
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && done)
        begin
            if (pending_inverses.size() == 0)
            begin
                report("unexpected result", 0, 0);
            end
            else
            begin
                want = pending_inverses.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (inv_ent[k] !== want.inv[k])
                    begin
                        report($sformatf("inv[%0d]", k), inv_ent[k], want.inv[k]);
                    end
                end
                if (not_inverted !== want.flag)
                begin
                    report("not_inverted", not_inverted, want.flag);
                end
            end
        end
    end

    // Drives one request, waits for acceptance, then an optional gap.
    task automatic send_matrix(mat_t e, int gap);
        for (int k = 0; k < 9; k++)
        begin
            in_ent[k] <= e[k];
        end
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_inverses.push_back(invert_matrix(e));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic mat_t diag_matrix(ent_t a, ent_t b, ent_t c);
        mat_t e;
        e = '{default: '0};
        e[0] = a;
        e[4] = b;
        e[8] = c;
        return e;
    endfunction

    task automatic test_directed();
        mat_t e;
        send_matrix(diag_matrix(ONE, ONE, ONE), 0);
        send_matrix(diag_matrix(2*ONE, ONE/2, 4*ONE), 1);
        send_matrix('{default: '0}, 0);
        send_matrix(diag_matrix(-ONE, ONE, ONE), 3);
        send_matrix(diag_matrix(-ONE, -ONE, -ONE), 0);
        // Tiny positive determinant drives the quotients into saturation.
        send_matrix(diag_matrix(1, 1, 1), 0);
        send_matrix(diag_matrix(1, -1, -1), 2);
        send_matrix('{default: MAX_ENT}, 0);
        send_matrix('{default: MIN_ENT}, 0);
        send_matrix(diag_matrix(MAX_ENT, MAX_ENT, MAX_ENT), 5);
        send_matrix(diag_matrix(MIN_ENT, MIN_ENT, MAX_ENT), 0);
        send_matrix(diag_matrix(MIN_ENT, MIN_ENT, MIN_ENT), 0);
        send_matrix('{MAX_ENT, MIN_ENT, MAX_ENT, MIN_ENT, MAX_ENT, MIN_ENT,
                      MAX_ENT, MIN_ENT, MIN_ENT}, 1);
        send_matrix('{MIN_ENT, MAX_ENT, 0, MAX_ENT, MIN_ENT, MAX_ENT, 0, MAX_ENT,
                      MIN_ENT}, 0);
        // Quarter-turn rotations about each axis.
        send_matrix('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}, 0);
        send_matrix('{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0}, 4);
        send_matrix('{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0}, 0);
        // Singular: two equal rows.
        send_matrix('{ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 5, 7, 9}, 0);
        e = '{default: '0};
        e[0] = -1;
        e[4] = -1;
        e[8] = 3;
        send_matrix(e, 12);
    endtask

    // Rotation-like matrices: angles from real math, plus small noise.
    task automatic test_rotations(int count);
        real a;
        real b;
        real ca;
        real sa;
        real cb;
        real sb;
        real r [9];
        real sc;
        mat_t e;
        bit burst;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                burst = $urandom_range(0, 1);
            end
            a = $urandom_range(0, 62831) / 10000.0;
            b = $urandom_range(0, 62831) / 10000.0;
            ca = $cos(a);
            sa = $sin(a);
            cb = $cos(b);
            sb = $sin(b);
            r = '{ca*cb, -sa, ca*sb, sa*cb, ca, sa*sb, -sb, 0.0, cb};
            sc = (1 << $urandom_range(0, 8)) / 16.0;
            for (int k = 0; k < 9; k++)
            begin
                e[k] = ent_t'($rtoi(r[k] * sc * 65536.0)) + ent_t'($urandom_range(0, 6)) - 3;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                e[$urandom_range(0, 8)] = -e[$urandom_range(0, 8)];
            end
            send_matrix(e, pick_gap(burst));
        end
    endtask

    task automatic test_random_entries(int count);
        mat_t e;
        bit burst;
        int mode;
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
            begin
                burst = $urandom_range(0, 1);
            end
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++)
            begin
                case (mode)
                    0: e[k] = ent_t'($urandom);
                    1: e[k] = ent_t'($urandom_range(0, 2*ONE)) - ONE;
                    2: e[k] = ent_t'($urandom_range(0, 64)) - 32;
                    default: e[k] = $urandom_range(0, 1) ? MAX_ENT - ent_t'($urandom_range(0, 3))
                                                         : MIN_ENT + ent_t'($urandom_range(0, 3));
                endcase
            end
            send_matrix(e, pick_gap(burst));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_rotations(1000);
        test_random_entries(530);
        start <= 1'b0;
        wait (pending_inverses.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS matrix3x3_inverse");
        end
        else
        begin
            $display("FAIL matrix3x3_inverse");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL matrix3x3_inverse");
        $finish;
    end

endmodule
